/* hw/rtl/slfr_pkg.sv */
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and codes of the sync and length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_LEGACY  = 2'd2;

  localparam logic [1:0] REG_SYNC_PATTERN = 2'd0;
  localparam logic [1:0] REG_MAX_LEN      = 2'd1;
  localparam logic [1:0] REG_LEGACY_ID    = 2'd2;

  localparam logic [31:0] SYNC_PATTERN_RST = 32'hAA55_AA55;
  localparam logic [7:0]  MAX_LEN_RST      = 8'd200;
  localparam logic [7:0]  LEGACY_ID_RST    = 8'h00;

  typedef struct packed {
    logic [31:0] sync_pattern;
    logic [7:0]  max_message_len;
    logic [7:0]  legacy_id;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  trailer_type;
    logic [23:0] sequence_res;
    logic [7:0]  frame_length;
    logic        is_repeat;
    logic        last;
  } res_t;

endpackage

/* hw/rtl/slfr_if.sv */
// ----------------------------------------------------------------------------
// slfr interfaces
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
interface slfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slfr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [7:0]  trailer_type;
  logic [23:0] sequence_res;
  logic [7:0]  frame_length;
  logic        is_repeat;
  logic        last;
  modport source (output valid, output out_kind, output data_byte, output byte_index,
                  output trailer_type, output sequence_res, output frame_length,
                  output is_repeat, output last, input ready);
  modport sink (input valid, input out_kind, input data_byte, input byte_index,
                input trailer_type, input sequence_res, input frame_length,
                input is_repeat, input last, output ready);
endinterface

interface slfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/slfr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// slfr_cfg_regs
// Configuration registers written through the register write channel.
// ----------------------------------------------------------------------------
module slfr_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  slfr_cfg_if.sink           cfg,
  output slfr_pkg::cfg_t     regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_pattern    <= slfr_pkg::SYNC_PATTERN_RST;
      regs.max_message_len <= slfr_pkg::MAX_LEN_RST;
      regs.legacy_id       <= slfr_pkg::LEGACY_ID_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        slfr_pkg::REG_SYNC_PATTERN: regs.sync_pattern    <= cfg.data;
        slfr_pkg::REG_MAX_LEN:      regs.max_message_len <= cfg.data[7:0];
        slfr_pkg::REG_LEGACY_ID:    regs.legacy_id       <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/slfr_parser.sv */
// ----------------------------------------------------------------------------
// slfr_parser
// Sync hunt and frame parsing state, one received byte per beat.
// ----------------------------------------------------------------------------
module slfr_parser (
  input  logic               clk,
  input  logic               rst,
  input  slfr_pkg::cfg_t     regs,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  output logic               has_res,
  output slfr_pkg::res_t     res
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_LEGACY  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_TYPE    = 3'd4;
  localparam logic [2:0] PH_SEQ0    = 3'd5;
  localparam logic [2:0] PH_SEQ1    = 3'd6;
  localparam logic [2:0] PH_SEQ2    = 3'd7;

  localparam logic [2:0] FILL_FULL = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [31:0] sync_window, sync_window_next;
  logic [2:0]  window_fill, window_fill_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  current_length, current_length_next;
  logic [7:0]  current_type, current_type_next;
  logic [23:0] sequence_accum, sequence_accum_next;
  logic [23:0] last_sequence, last_sequence_next;
  logic        last_sequence_valid, last_sequence_valid_next;

  logic [31:0] win_push;
  logic [2:0]  fill_inc;
  logic        sync_hit;
  logic [7:0]  count_inc;
  logic [23:0] seq_shift;

  assign win_push  = {sync_window[23:0], rx_byte};
  assign fill_inc  = (window_fill < FILL_FULL) ? window_fill + 3'd1 : window_fill;
  assign sync_hit  = (fill_inc == FILL_FULL) && (win_push == regs.sync_pattern);
  assign count_inc = payload_count + 8'd1;
  assign seq_shift = {sequence_accum[15:0], rx_byte};

  always_comb begin
    phase_next               = phase;
    sync_window_next         = sync_window;
    window_fill_next         = window_fill;
    payload_count_next       = payload_count;
    current_length_next      = current_length;
    current_type_next        = current_type;
    sequence_accum_next      = sequence_accum;
    last_sequence_next       = last_sequence;
    last_sequence_valid_next = last_sequence_valid;
    has_res                  = 1'b0;
    res                      = '0;
    case (phase)
      PH_HEADER: begin
        if (rx_byte == regs.legacy_id) begin
          phase_next = PH_LEGACY;
        end else if (rx_byte == 8'd0 || rx_byte > regs.max_message_len) begin
          sync_window_next = win_push;
          window_fill_next = fill_inc;
          phase_next       = sync_hit ? PH_HEADER : PH_HUNT;
        end else begin
          current_length_next = rx_byte;
          payload_count_next  = 8'd0;
          phase_next          = PH_PAYLOAD;
        end
      end
      PH_LEGACY: begin
        has_res          = 1'b1;
        res.out_kind     = slfr_pkg::KIND_LEGACY;
        res.data_byte    = rx_byte;
        res.last         = 1'b1;
        phase_next       = PH_HUNT;
        sync_window_next = '0;
        window_fill_next = '0;
      end
      PH_PAYLOAD: begin
        has_res            = 1'b1;
        res.out_kind       = slfr_pkg::KIND_PAYLOAD;
        res.data_byte      = rx_byte;
        res.byte_index     = payload_count;
        res.frame_length   = current_length;
        payload_count_next = count_inc;
        if (count_inc >= current_length) begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        current_type_next   = rx_byte;
        sequence_accum_next = '0;
        phase_next          = PH_SEQ0;
      end
      PH_SEQ0: begin
        sequence_accum_next = seq_shift;
        phase_next          = PH_SEQ1;
      end
      PH_SEQ1: begin
        sequence_accum_next = seq_shift;
        phase_next          = PH_SEQ2;
      end
      PH_SEQ2: begin
        has_res                  = 1'b1;
        res.out_kind             = slfr_pkg::KIND_END;
        res.trailer_type         = current_type;
        res.sequence_res         = seq_shift;
        res.frame_length         = current_length;
        res.is_repeat            = last_sequence_valid && (seq_shift == last_sequence);
        res.last                 = 1'b1;
        sequence_accum_next      = seq_shift;
        last_sequence_next       = seq_shift;
        last_sequence_valid_next = 1'b1;
        phase_next               = PH_HUNT;
        sync_window_next         = '0;
        window_fill_next         = '0;
      end
      default: begin
        sync_window_next = win_push;
        window_fill_next = fill_inc;
        phase_next       = sync_hit ? PH_HEADER : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_HUNT;
      sync_window         <= '0;
      window_fill         <= '0;
      payload_count       <= '0;
      current_length      <= '0;
      current_type        <= '0;
      sequence_accum      <= '0;
      last_sequence       <= '0;
      last_sequence_valid <= 1'b0;
    end else if (take) begin
      phase               <= phase_next;
      sync_window         <= sync_window_next;
      window_fill         <= window_fill_next;
      payload_count       <= payload_count_next;
      current_length      <= current_length_next;
      current_type        <= current_type_next;
      sequence_accum      <= sequence_accum_next;
      last_sequence       <= last_sequence_next;
      last_sequence_valid <= last_sequence_valid_next;
    end
  end

endmodule

/* hw/rtl/slfr_out_reg.sv */
// ----------------------------------------------------------------------------
// slfr_out_reg
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module slfr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  slfr_pkg::res_t     res_in,
  output logic               space,
  output logic               valid,
  input  logic               ready,
  output slfr_pkg::res_t     res_out
);

  logic valid_next;

  assign space = !valid || ready;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* hw/rtl/sync_length_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Byte-serial deframer: sync word hunt, legacy commands and length frames.
//
// rx carries one received byte per beat. While hunting, the last four bytes
// are compared with the sync pattern; after sync a legacy id byte is followed
// by one command byte, otherwise a length byte is followed by the payload,
// a type byte and a 24-bit big-endian sequence.
// res carries at most one result per received byte: each payload byte, the
// frame end with type, sequence and repeat flag, or the legacy command.
// cfg writes sync_pattern (index 0), max_message_len (1) and legacy_id (2);
// it is always ready and should be written only while the block is idle.
// Throughput is one byte per cycle unless rx stalls; a result appears on res in
// the cycle after its byte is taken, held in a single output register.
// rx stalls only while that register holds a result that res does not take.
// Reset clears the parser to the hunt with an empty window, forgets the last
// sequence, empties the output register and restores the register defaults.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  slfr_rx_if.sink    rx,
  slfr_res_if.source res,
  slfr_cfg_if.sink   cfg
);

  slfr_pkg::cfg_t regs;
  slfr_pkg::res_t parse_res;
  slfr_pkg::res_t out_res;
  logic           has_res;
  logic           space;
  logic           take;

  assign rx.ready = space;
  assign take     = rx.valid && space;

  slfr_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  slfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .has_res (has_res),
    .res     (parse_res)
  );

  slfr_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (take && has_res),
    .res_in  (parse_res),
    .space   (space),
    .valid   (res.valid),
    .ready   (res.ready),
    .res_out (out_res)
  );

  assign res.out_kind     = out_res.out_kind;
  assign res.data_byte    = out_res.data_byte;
  assign res.byte_index   = out_res.byte_index;
  assign res.trailer_type = out_res.trailer_type;
  assign res.sequence_res = out_res.sequence_res;
  assign res.frame_length = out_res.frame_length;
  assign res.is_repeat    = out_res.is_repeat;
  assign res.last         = out_res.last;

endmodule

/* hw/rtl/slfr_checker.sv */
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  data_byte,
  input logic        is_repeat,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_kind) && $stable(data_byte))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (out_kind == slfr_pkg::KIND_PAYLOAD || out_kind == slfr_pkg::KIND_END ||
                   out_kind == slfr_pkg::KIND_LEGACY))
    else $error("unknown result kind");

  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last == (out_kind != slfr_pkg::KIND_PAYLOAD)))
    else $error("last flag does not match result kind");

  a_repeat: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_kind != slfr_pkg::KIND_END |-> !is_repeat && !(out_kind ==
      slfr_pkg::KIND_END))
    else $error("repeat flag outside frame end");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .out_kind  (res.out_kind),
  .data_byte (res.data_byte),
  .is_repeat (res.is_repeat),
  .last      (res.last)
);

/* test/tb_sync_length_frame_receiver.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_frame_receiver
// Self-checking bench for the sync and length frame receiver.
//
// Directed tests cover the reset settings, legacy commands, stream frames from
// one byte up to 255 bytes, bad lengths with an instant resync, a zero limit,
// the short window after a frame and repeated sequences. Random rounds follow
// under random register settings, mostly well-formed frames and legacy commands
// with random content, mixed with cut-off sync words, bad lengths and line noise.
// A behavioral deframer tracks every accepted byte and queues the results it
// implies; the result monitor compares each beat against the oldest one, field
// by field. The byte sender runs in random bursts, the result side stalls on a
// rotating pattern, and one long hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_receiver;

  typedef enum logic [2:0] {
    P_HUNT, P_HEADER, P_LEGACY, P_PAYLOAD, P_TYPE, P_SEQ0, P_SEQ1, P_SEQ2
  } parse_phase_t;

  logic clk;
  logic rst;

  slfr_rx_if  rx_ch ();
  slfr_res_if res_ch ();
  slfr_cfg_if cfg_ch ();

  sync_length_frame_receiver DUT (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  logic [31:0]      model_sync;
  logic [7:0]       model_max_len;
  logic [7:0]       model_legacy_id;
  parse_phase_t     model_phase;
  logic [31:0]      model_window;
  int               model_fill;
  logic [7:0]       model_count;
  logic [7:0]       model_length;
  logic [7:0]       model_type;
  logic [23:0]      model_seq;
  logic [23:0]      model_last_seq;
  logic             model_last_seq_valid;
  slfr_pkg::res_t   pending_results[$];

  int          gap_max = 4;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          reg_writes = 0;
  logic [23:0] last_sent_seq = '0;
  int          hold_req = 0;
  int          hold_len = 0;
  logic        hold_off;

  int errors = 0;
  int n_payload = 0;
  int n_frame_end = 0;
  int n_repeat = 0;
  int n_legacy = 0;
  int rx_stalls = 0;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 30) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // ---- deframer prediction ----
  task automatic reset_model();
    model_sync           = slfr_pkg::SYNC_PATTERN_RST;
    model_max_len        = slfr_pkg::MAX_LEN_RST;
    model_legacy_id      = slfr_pkg::LEGACY_ID_RST;
    model_phase          = P_HUNT;
    model_window         = '0;
    model_fill           = 0;
    model_count          = '0;
    model_length         = '0;
    model_type           = '0;
    model_seq            = '0;
    model_last_seq       = '0;
    model_last_seq_valid = 1'b0;
  endtask

  task automatic shift_window(input logic [7:0] b);
    model_window = {model_window[23:0], b};
    if (model_fill < 4) model_fill++;
    model_phase = (model_fill >= 4 && model_window == model_sync) ? P_HEADER : P_HUNT;
  endtask

  task automatic clear_window();
    model_phase  = P_HUNT;
    model_window = '0;
    model_fill   = 0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    slfr_pkg::res_t r;
    r = '0;
    case (model_phase)
      P_HEADER: begin
        if (b == model_legacy_id) begin
          model_phase = P_LEGACY;
        end else if (b == 8'd0 || b > model_max_len) begin
          shift_window(b);
        end else begin
          model_length = b;
          model_count  = '0;
          model_phase  = P_PAYLOAD;
        end
      end
      P_LEGACY: begin
        r.out_kind  = slfr_pkg::KIND_LEGACY;
        r.data_byte = b;
        r.last      = 1'b1;
        pending_results.push_back(r);
        clear_window();
      end
      P_PAYLOAD: begin
        r.out_kind     = slfr_pkg::KIND_PAYLOAD;
        r.data_byte    = b;
        r.byte_index   = model_count;
        r.frame_length = model_length;
        pending_results.push_back(r);
        model_count++;
        if (model_count >= model_length) model_phase = P_TYPE;
      end
      P_TYPE: begin
        model_type  = b;
        model_seq   = '0;
        model_phase = P_SEQ0;
      end
      P_SEQ0: begin
        model_seq   = {model_seq[15:0], b};
        model_phase = P_SEQ1;
      end
      P_SEQ1: begin
        model_seq   = {model_seq[15:0], b};
        model_phase = P_SEQ2;
      end
      P_SEQ2: begin
        model_seq      = {model_seq[15:0], b};
        r.out_kind     = slfr_pkg::KIND_END;
        r.trailer_type = model_type;
        r.sequence_res = model_seq;
        r.frame_length = model_length;
        r.is_repeat    = model_last_seq_valid && (model_seq == model_last_seq);
        r.last         = 1'b1;
        pending_results.push_back(r);
        model_last_seq       = model_seq;
        model_last_seq_valid = 1'b1;
        clear_window();
      end
      default: shift_window(b);
    endcase
  endtask

  // ---- byte sender ----
  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    deframe_byte(b);
    bytes_sent++;
    if (gap_max > 0 && burst_left == 0) begin
      gap        = $urandom_range(1, gap_max);
      burst_left = $urandom_range(0, 15);
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic send_sync();
    for (int i = 3; i >= 0; i--) send_byte(model_sync[8*i +: 8]);
  endtask

  task automatic send_length_frame(input int len, input logic [7:0] msg_type,
                                   input logic [23:0] seq);
    send_sync();
    send_byte(8'(len));
    repeat (len) send_byte(8'($urandom));
    send_byte(msg_type);
    send_byte(seq[23:16]);
    send_byte(seq[15:8]);
    send_byte(seq[7:0]);
    last_sent_seq = seq;
  endtask

  task automatic send_legacy(input logic [7:0] cmd);
    send_sync();
    send_byte(model_legacy_id);
    send_byte(cmd);
  endtask

  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---- register writes, idle block only ----
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      slfr_pkg::REG_SYNC_PATTERN: model_sync = value;
      slfr_pkg::REG_MAX_LEN:      model_max_len = value[7:0];
      slfr_pkg::REG_LEGACY_ID:    model_legacy_id = value[7:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic [31:0] sync, input logic [7:0] max_len,
                            input logic [7:0] legacy);
    write_reg(slfr_pkg::REG_SYNC_PATTERN, sync);
    write_reg(slfr_pkg::REG_MAX_LEN, {24'd0, max_len});
    write_reg(slfr_pkg::REG_LEGACY_ID, {24'd0, legacy});
  endtask

  // ---- tests ----
  task automatic test_default_frames();
    gap_max = 4;
    // zero byte after sync is the legacy id, not a zero length
    send_legacy(8'hFF);
    send_length_frame(1, 8'hFF, 24'hFFFFFF);
    send_length_frame(2, 8'h00, 24'hFFFFFF);
    send_sync();
    send_byte(8'd201);
    send_length_frame(3, 8'h5A, 24'h000000);
  endtask

  task automatic test_short_window();
    set_config(32'h0000_0000, 8'd255, 8'hFE);
    // three zeros on an empty window must not match
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h07);
    send_sync();
    // zero length keeps an all-zero window, so sync is found again at once
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'hA5);
    send_length_frame(255, 8'h81, 24'h800001);
  endtask

  task automatic test_zero_max();
    set_config(32'hFFFF_FFFF, 8'd0, 8'h5A);
    send_sync();
    send_byte(8'h01);
    repeat (4) send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h00);
  endtask

  task automatic test_min_max_len();
    set_config(32'h1234_5678, 8'd1, 8'h80);
    send_length_frame(1, 8'h01, 24'h123456);
    send_sync();
    send_byte(8'h02);
    send_length_frame(1, 8'hFE, 24'h123456);
    send_legacy(8'h80);
  endtask

  task automatic test_backpressure();
    set_config(slfr_pkg::SYNC_PATTERN_RST, slfr_pkg::MAX_LEN_RST, slfr_pkg::LEGACY_ID_RST);
    gap_max  = 0;
    hold_len = 150;
    hold_req <= hold_req + 1;
    send_length_frame(40, 8'($urandom), 24'($urandom));
    gap_max = 4;
  endtask

  task automatic test_random_traffic();
    int          target;
    int          choice;
    int          len;
    int          n;
    int          lim;
    logic [7:0]  max_len;
    logic [7:0]  bad_len;
    logic [23:0] seq;
    for (int round = 0; round < 6; round++) begin
      case ($urandom_range(0, 3))
        0:       max_len = 8'($urandom_range(1, 4));
        1:       max_len = 8'($urandom_range(5, 24));
        2:       max_len = 8'($urandom_range(0, 255));
        default: max_len = (round % 2) ? 8'd255 : 8'd1;
      endcase
      set_config($urandom, max_len, 8'($urandom_range(0, 255)));
      gap_max = (round == 2) ? 0 : $urandom_range(1, 8);
      target  = bytes_sent + 15;
      while (bytes_sent < target) begin
        choice = $urandom_range(0, 99);
        if (choice < 50) begin
          lim = (model_max_len == 0) ? 8 : ((model_max_len < 16) ? model_max_len : 16);
          len = $urandom_range(1, lim);
          if (choice < 2 && model_max_len != 0) len = model_max_len;
          seq = ($urandom_range(0, 3) == 0) ? last_sent_seq : 24'($urandom);
          send_length_frame(len, 8'($urandom), seq);
        end else if (choice < 70) begin
          send_legacy(8'($urandom));
        end else if (choice < 85) begin
          if ($urandom_range(0, 1) == 1) begin
            if (model_max_len == 8'd255 || $urandom_range(0, 1) == 0) bad_len = 8'd0;
            else bad_len = 8'($urandom_range(model_max_len + 1, 255));
            send_sync();
            send_byte(bad_len);
          end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) send_byte(model_sync[31 - 8*i -: 8]);
          end
        end else begin
          // line noise does not count toward the round
          n = $urandom_range(1, 6);
          repeat (n) send_byte(8'($urandom));
          target += n;
        end
      end
    end
  endtask

  // ---- long hold-off on the result side ----
  initial begin
    int hold_seen;
    hold_seen = 0;
    hold_off <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_off <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_off <= 1'b0;
      end
    end
  end

  // ---- result monitor and receiver stalls ----
  initial begin
    slfr_pkg::res_t seen;
    slfr_pkg::res_t want;
    int             cyc;
    logic           ready_next;
    cyc = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rx_ch.valid === 1'b1 && rx_ch.ready === 1'b0) rx_stalls++;
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        seen = {res_ch.out_kind, res_ch.data_byte, res_ch.byte_index, res_ch.trailer_type,
                res_ch.sequence_res, res_ch.frame_length, res_ch.is_repeat, res_ch.last};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, kind %0d",
                                    seen.out_kind));
        end else begin
          want = pending_results.pop_front();
          check_field("out_kind", seen.out_kind, want.out_kind);
          check_field("data_byte", seen.data_byte, want.data_byte);
          check_field("byte_index", seen.byte_index, want.byte_index);
          check_field("trailer_type", seen.trailer_type, want.trailer_type);
          check_field("sequence_res", seen.sequence_res, want.sequence_res);
          check_field("frame_length", seen.frame_length, want.frame_length);
          check_field("is_repeat", seen.is_repeat, want.is_repeat);
          check_field("last", seen.last, want.last);
          case (want.out_kind)
            slfr_pkg::KIND_PAYLOAD: n_payload++;
            slfr_pkg::KIND_END: begin
              n_frame_end++;
              if (want.is_repeat) n_repeat++;
            end
            slfr_pkg::KIND_LEGACY: n_legacy++;
            default: ;
          endcase
        end
      end
      cyc++;
      case ((cyc / 300) % 4)
        0:       ready_next = 1'b1;
        1:       ready_next = ($urandom_range(0, 1) == 0);
        2:       ready_next = ((cyc % 7) >= 3);
        default: ready_next = ($urandom_range(0, 9) != 0);
      endcase
      res_ch.ready <= ready_next && !hold_off;
    end
  end

  // ---- run limit ----
  initial begin
    #1ms;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= slfr_pkg::REG_SYNC_PATTERN;
    cfg_ch.data   <= '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_default_frames();
    test_short_window();
    test_zero_max();
    test_min_max_len();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("sent %0d bytes over %0d register writes, input stalled %0d cycles",
             bytes_sent, reg_writes, rx_stalls);
    $display("checked %0d payload beats, %0d frame ends (%0d repeats), %0d legacy commands",
             n_payload, n_frame_end, n_repeat, n_legacy);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
